[rtl/psbd_pkg.sv]
// shared types, constants and helpers of the phase switch breakpoint detector
`timescale 1ns / 1ps
`default_nettype none

package psbd_pkg;

    localparam int MAX_MARKERS = 4096;
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int PHASE_W     = 2;

    // marker index saturates at the smaller of the sequence bound and the index range
    localparam int IdxLimitInt = ((MAX_MARKERS - 1) > ((1 << IDX_W) - 1))
                                 ? ((1 << IDX_W) - 1) : (MAX_MARKERS - 1);
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(IdxLimitInt);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MIN_FLANK_RESET = CNT_W'(1);

    // result queue: one marker can cause up to three results
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int QCNT_W      = 3;
    localparam int MAX_PUSH    = 3;
    localparam int PUSH_W      = 2;

    typedef struct packed {
        logic [IDX_W-1:0] break_position;
        logic             is_summary;
        logic [CNT_W-1:0] break_total;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room;
    } queue_status_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/psbd_queue.sv]
// result queue that takes up to three results per beat and gives one per beat
`timescale 1ns / 1ps
`default_nettype none

module psbd_queue
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic [psbd_pkg::PUSH_W-1:0]             push_n,
    input  wire psbd_pkg::result_t [psbd_pkg::MAX_PUSH-1:0] push_data,
    output psbd_pkg::queue_status_t                       status,
    output logic                                         pop_valid,
    input  wire logic                                    pop_ready,
    output psbd_pkg::result_t                             pop_data
);
    import psbd_pkg::*;

    result_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               pop;

    assign pop        = pop_valid && pop_ready;
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    // room for a full three-result burst
    assign status.room  = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_PUSH));
    assign status.count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PUSH; k++)
        begin
            if (k < int'(push_n))
            begin
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/phase_switch_breakpoint_detector_core.sv]
// top level of the phase switch breakpoint detector
`timescale 1ns / 1ps
`default_nettype none

// a marker beat is taken and its results are written into the result queue for the master side
// throughput: one marker per cycle while the queue holds at most one result; a last marker
//   can cause three results, which the four-entry queue drains one per cycle unless stalled
// reset: rst_n clears all sequence state and the queue, min_flank returns to 1
// all sequence state also returns to its reset value after the summary beat is queued
module phase_switch_breakpoint_detector_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: min_flank
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata,
    // marker stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [1:0] ref_phase, [3:2] sib_phase, [7:4] zero
    input  wire logic        s_axis_tlast,   // last_marker
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [11:0] break_position, [24:12] break_total,
                                             // [31:25] zero
    output logic             m_axis_tuser,   // is_summary
    output logic             m_axis_tlast    // last_result
);
    import psbd_pkg::*;

    // configuration register
    logic [CNT_W-1:0]   min_flank_reg;

    // sequence state
    logic [IDX_W-1:0]   marker_index_reg;
    logic [IDX_W-1:0]   marker_index_next;
    logic               prev_valid_reg;
    logic               prev_valid_next;
    logic               prev_match_reg;
    logic               prev_match_next;
    logic [CNT_W-1:0]   seg_count_reg;
    logic [CNT_W-1:0]   seg_count_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [IDX_W-1:0]   pend_pos_reg;
    logic [IDX_W-1:0]   pend_pos_next;
    logic [CNT_W-1:0]   pend_before_reg;
    logic [CNT_W-1:0]   pend_before_next;
    logic [CNT_W-1:0]   acc_count_reg;
    logic [CNT_W-1:0]   acc_count_next;

    // per-beat decode
    logic [PHASE_W-1:0] ref_phase;
    logic [PHASE_W-1:0] sib_phase;
    logic               last_marker;
    logic               accept;
    logic               informative;
    logic               match;
    logic               is_break;
    logic [CNT_W-1:0]   seg_inc;
    logic               dec_prev;       // earlier pending break accepted at this break
    logic               dec_last;       // break pending at the last marker accepted
    logic [CNT_W-1:0]   acc_mid;
    logic               mid_pend_valid;
    logic [IDX_W-1:0]   mid_pend_pos;
    logic [CNT_W-1:0]   mid_pend_before;
    logic [CNT_W-1:0]   mid_seg;

    result_t            res_prev;
    result_t            res_last;
    result_t            res_summary;
    result_t [MAX_PUSH-1:0] push_data;
    logic [PUSH_W-1:0]  push_n;
    queue_status_t      q_status;
    result_t            out_res;

    assign ref_phase   = s_axis_tdata[1:0];
    assign sib_phase   = s_axis_tdata[3:2];
    assign last_marker = s_axis_tlast;
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = q_status.room;

    always_comb
    begin
        // a negative phase (sign bit set) is uninformative
        informative = !ref_phase[1] && !sib_phase[1];
        match       = (ref_phase == sib_phase);
        seg_inc     = sat_inc(seg_count_reg);
        is_break    = informative && prev_valid_reg && (match != prev_match_reg);

        // the break marker closes the segment before it and opens an empty one
        dec_prev = is_break && pend_valid_reg && (pend_before_reg >= min_flank_reg)
                   && (seg_inc >= min_flank_reg);
        acc_mid  = dec_prev ? sat_inc(acc_count_reg) : acc_count_reg;

        if (is_break)
        begin
            mid_pend_valid  = 1'b1;
            mid_pend_pos    = marker_index_reg;
            mid_pend_before = seg_inc;
            mid_seg         = '0;
        end
        else
        begin
            mid_pend_valid  = pend_valid_reg;
            mid_pend_pos    = pend_pos_reg;
            mid_pend_before = pend_before_reg;
            mid_seg         = informative ? seg_inc : seg_count_reg;
        end

        // the last marker closes the segment after the pending break
        dec_last = last_marker && mid_pend_valid && (mid_pend_before >= min_flank_reg)
                   && (mid_seg >= min_flank_reg);
        acc_count_next = dec_last ? sat_inc(acc_mid) : acc_mid;

        prev_valid_next  = informative ? 1'b1 : prev_valid_reg;
        prev_match_next  = informative ? match : prev_match_reg;
        seg_count_next   = mid_seg;
        pend_valid_next  = mid_pend_valid;
        pend_pos_next    = mid_pend_pos;
        pend_before_next = mid_pend_before;
        marker_index_next = (marker_index_reg < IDX_LIMIT)
                            ? marker_index_reg + IDX_W'(1) : marker_index_reg;

        // results in order: earlier break, break at last marker, summary
        res_prev.break_position = pend_pos_reg;
        res_prev.is_summary     = 1'b0;
        res_prev.break_total    = '0;
        res_prev.last_result    = !last_marker;

        res_last.break_position = mid_pend_pos;
        res_last.is_summary     = 1'b0;
        res_last.break_total    = '0;
        res_last.last_result    = 1'b0;

        res_summary.break_position = '0;
        res_summary.is_summary     = 1'b1;
        res_summary.break_total    = acc_count_next;
        res_summary.last_result    = 1'b1;

        push_data[0] = dec_prev ? res_prev : (dec_last ? res_last : res_summary);
        push_data[1] = (dec_prev && dec_last) ? res_last : res_summary;
        push_data[2] = res_summary;

        if (accept)
        begin
            push_n = PUSH_W'(dec_prev) + PUSH_W'(dec_last) + PUSH_W'(last_marker);
        end
        else
        begin
            push_n = '0;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_flank_reg <= MIN_FLANK_RESET;
        end
        else if (cfg_we)
        begin
            min_flank_reg <= cfg_wdata;
        end
    end

    // sequence state, cleared after the summary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_index_reg <= '0;
            prev_valid_reg   <= 1'b0;
            prev_match_reg   <= 1'b0;
            seg_count_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            pend_pos_reg     <= '0;
            pend_before_reg  <= '0;
            acc_count_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_marker)
            begin
                marker_index_reg <= '0;
                prev_valid_reg   <= 1'b0;
                prev_match_reg   <= 1'b0;
                seg_count_reg    <= '0;
                pend_valid_reg   <= 1'b0;
                pend_pos_reg     <= '0;
                pend_before_reg  <= '0;
                acc_count_reg    <= '0;
            end
            else
            begin
                marker_index_reg <= marker_index_next;
                prev_valid_reg   <= prev_valid_next;
                prev_match_reg   <= prev_match_next;
                seg_count_reg    <= seg_count_next;
                pend_valid_reg   <= pend_valid_next;
                pend_pos_reg     <= pend_pos_next;
                pend_before_reg  <= pend_before_next;
                acc_count_reg    <= acc_count_next;
            end
        end
    end

    // result queue parts the marker side from the result side
    psbd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (push_data),
        .status    (q_status),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (out_res)
    );

    assign m_axis_tdata = {7'b0, out_res.break_total, out_res.break_position};
    assign m_axis_tuser = out_res.is_summary;
    assign m_axis_tlast = out_res.last_result;

`ifndef SYNTHESIS
    // a finished sequence leaves no state behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_marker) |=> (marker_index_reg == '0 && !pend_valid_reg
                                     && acc_count_reg == '0 && !prev_valid_reg))
        else $error("sequence state not cleared after last marker");

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // the summary beat always closes the results of its marker
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("summary beat without last_result");

    // a breakpoint beat carries no total
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[24:12] == '0))
        else $error("breakpoint beat with nonzero total");
`endif

endmodule

`default_nettype wire
